>>> design/rgb_box_blur_3x3_macros.svh
// Assertion macros shared by the box blur RTL.
`ifndef RGB_BOX_BLUR_3X3_MACROS_SVH
`define RGB_BOX_BLUR_3X3_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BBX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BBX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/bbx_pkg.sv
// Types and constants of the 3x3 box blur.
package bbx_pkg;

  localparam int PIX_W      = 8;
  localparam int COORD_W    = 11;
  localparam int CFG_W      = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CSUM_W     = 10;
  localparam int SUM_W      = 12;
  localparam int RECIP_W    = 13;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W     = SUM_W + RECIP_W;

  localparam logic [RECIP_W-1:0] RECIP_9 = 13'd7282;
  localparam logic [CFG_W-1:0] CFG_RESET_SIZE = 12'd2048;

  localparam int MAX_RESULTS = 3;
  localparam int FIFO_DEPTH  = 16;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = FIFO_PTR_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pix_t;

  localparam int PIX_BITS = $bits(pix_t);

  typedef struct packed {
    logic               has_first;
    logic               interior;
    logic               has_up;
    logic               has_own;
    logic               row_end;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } tag_t;

  typedef struct packed {
    tag_t tag;
    pix_t up;
    pix_t own;
  } carry_t;

  typedef struct packed {
    pix_t               pix;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
    logic               done;
  } res_t;

endpackage

>>> design/bbx_in_if.sv
// Pixel input channel.
interface bbx_in_if import bbx_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] in_red;
  logic [PIX_W-1:0] in_green;
  logic [PIX_W-1:0] in_blue;

  modport source (output valid, output in_red, output in_green, output in_blue,
                  input ready);
  modport sink (input valid, input in_red, input in_green, input in_blue,
                output ready);
endinterface

>>> design/bbx_out_if.sv
// Result pixel output channel.
interface bbx_out_if import bbx_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   out_red;
  logic [PIX_W-1:0]   out_green;
  logic [PIX_W-1:0]   out_blue;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_column;
  logic               last_of_run;
  logic               frame_done;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output out_row, output out_column, output last_of_run,
                  output frame_done, input ready);
  modport sink (input valid, input out_red, input out_green, input out_blue,
                input out_row, input out_column, input last_of_run,
                input frame_done, output ready);
endinterface

>>> design/bbx_cfg_if.sv
// Configuration write channel.
interface bbx_cfg_if import bbx_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/bbx_line_mem.sv
// Line store memory: one write port, one registered read port.
module bbx_line_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int DW    = 48
) (
  input  logic          clk,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we_i) begin
      mem_r[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_r <= mem_r[raddr_i];
    end
  end

  assign rdata_o = rdata_r;

endmodule

>>> design/bbx_blur.sv
// Window column sums, 3x3 total and divide by nine.
module bbx_blur import bbx_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   valid_i,
  input  pix_t   older_i,
  input  pix_t   up_i,
  input  carry_t carry_i,
  output logic   valid_o,
  output carry_t carry_o,
  output pix_t   blur_o,
  output pix_t   center_o
);

  typedef struct packed {
    logic [CSUM_W-1:0] red;
    logic [CSUM_W-1:0] green;
    logic [CSUM_W-1:0] blue;
  } csum_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } sum_t;

  function automatic csum_t col_sum(pix_t a, pix_t b, pix_t c);
    col_sum.red   = CSUM_W'(a.red) + CSUM_W'(b.red) + CSUM_W'(c.red);
    col_sum.green = CSUM_W'(a.green) + CSUM_W'(b.green) + CSUM_W'(c.green);
    col_sum.blue  = CSUM_W'(a.blue) + CSUM_W'(b.blue) + CSUM_W'(c.blue);
  endfunction

  // Window: column sums of the three columns, middle pixel of the newest one.
  csum_t  cs0_r, cs1_r, cs2_r;
  pix_t   mid2_r;

  logic   a_valid_r, b_valid_r, c_valid_r;
  carry_t a_carry_r, b_carry_r, c_carry_r;
  pix_t   a_center_r, b_center_r, c_center_r;
  sum_t   b_tot_r;
  sum_t   tot;
  pix_t   c_blur_r;
  logic [PROD_W-1:0] prod_red, prod_green, prod_blue;

  always_comb begin
    tot.red   = SUM_W'(cs0_r.red) + SUM_W'(cs1_r.red) + SUM_W'(cs2_r.red);
    tot.green = SUM_W'(cs0_r.green) + SUM_W'(cs1_r.green) + SUM_W'(cs2_r.green);
    tot.blue  = SUM_W'(cs0_r.blue) + SUM_W'(cs1_r.blue) + SUM_W'(cs2_r.blue);
    prod_red   = PROD_W'(b_tot_r.red) * PROD_W'(RECIP_9);
    prod_green = PROD_W'(b_tot_r.green) * PROD_W'(RECIP_9);
    prod_blue  = PROD_W'(b_tot_r.blue) * PROD_W'(RECIP_9);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      a_valid_r <= valid_i;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i) begin
      cs0_r      <= cs1_r;
      cs1_r      <= cs2_r;
      cs2_r      <= col_sum(older_i, up_i, carry_i.own);
      mid2_r     <= up_i;
      a_center_r <= mid2_r;
      a_carry_r  <= carry_i;
    end
    if (a_valid_r) begin
      b_tot_r    <= tot;
      b_center_r <= a_center_r;
      b_carry_r  <= a_carry_r;
    end
    if (b_valid_r) begin
      c_blur_r.red   <= prod_red[RECIP_SHIFT +: PIX_W];
      c_blur_r.green <= prod_green[RECIP_SHIFT +: PIX_W];
      c_blur_r.blue  <= prod_blue[RECIP_SHIFT +: PIX_W];
      c_center_r     <= b_center_r;
      c_carry_r      <= b_carry_r;
    end
  end

  assign valid_o  = c_valid_r;
  assign carry_o  = c_carry_r;
  assign blur_o   = c_blur_r;
  assign center_o = c_center_r;

endmodule

>>> design/bbx_result_fifo.sv
// Result queue taking up to three entries per cycle and giving one while the reader is ready.
module bbx_result_fifo import bbx_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [MAX_RESULTS-1:0] push_i,
  input  res_t                  ent_i [MAX_RESULTS],
  output logic                  valid_o,
  input  logic                  ready_i,
  output res_t                  ent_o,
  output logic [FIFO_CNT_W-1:0] count_o
);

  res_t                  entries_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr_r, wptr_nxt;
  logic [FIFO_PTR_W-1:0] rptr_r, rptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;
  logic [1:0]            off1, off2, push_n;
  logic [FIFO_PTR_W-1:0] wr_idx [MAX_RESULTS];
  logic                  pop;

  always_comb begin
    off1      = {1'b0, push_i[0]};
    off2      = {1'b0, push_i[0]} + {1'b0, push_i[1]};
    push_n    = off2 + {1'b0, push_i[2]};
    wr_idx[0] = wptr_r;
    wr_idx[1] = wptr_r + FIFO_PTR_W'(off1);
    wr_idx[2] = wptr_r + FIFO_PTR_W'(off2);
    pop       = valid_o && ready_i;
    wptr_nxt  = wptr_r + FIFO_PTR_W'(push_n);
    rptr_nxt  = rptr_r + FIFO_PTR_W'(pop);
    count_nxt = count_r + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (push_i[i]) begin
        entries_r[wr_idx[i]] <= ent_i[i];
      end
    end
  end

  assign valid_o = (count_r != '0);
  assign ent_o   = entries_r[rptr_r];
  assign count_o = count_r;

endmodule

>>> design/rgb_box_blur_3x3.sv
// 3x3 box blur: accepted pixels pass the line store read, the blur stages and the result queue.
// Throughput: one pixel per cycle while results drain at one per cycle;
// row ends and the last row make up to three results, and the single output
// port then sets the pace through a 16-entry result queue.
// Reset: counters to zero, sizes to 2048; line stores are not cleared.
module rgb_box_blur_3x3 import bbx_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic       clk,
  input  logic       rst_n,
  bbx_cfg_if.sink    cfg_chan,
  bbx_in_if.sink     in_chan,
  bbx_out_if.source  out_chan
);

  `include "rgb_box_blur_3x3_macros.svh"

  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int YW   = $clog2(MAX_HEIGHT);
  localparam int XYW  = (XW > YW) ? XW : YW;
  // Compare width: holds the configured sizes and MAX_* themselves.
  localparam int CMPW = ((XYW > CFG_W) ? XYW : CFG_W) + 1;
  localparam int OCCW = FIFO_CNT_W + 1;

  function automatic logic [1:0] res_count(tag_t t);
    res_count = {1'b0, t.has_first} + {1'b0, t.has_up} + {1'b0, t.has_own};
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers; the port never stalls.
  // ---------------------------------------------------------------------
  logic [CFG_W-1:0] width_r, height_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_RESET_SIZE;
      height_r <= CFG_RESET_SIZE;
    end else if (cfg_chan.valid) begin
      case (cfg_reg_t'(cfg_chan.index))
        REG_IMAGE_WIDTH:  width_r  <= cfg_chan.data;
        REG_IMAGE_HEIGHT: height_r <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  // Clamp sizes to [1, MAX] and form the last column and last row index.
  logic [CMPW-1:0] wcfg, hcfg, w_eff, h_eff, wm1, hm1, xw, yw;

  always_comb begin
    wcfg = CMPW'(width_r);
    hcfg = CMPW'(height_r);
    if (wcfg == '0) begin
      w_eff = CMPW'(1);
    end else if (wcfg > CMPW'(MAX_WIDTH)) begin
      w_eff = CMPW'(MAX_WIDTH);
    end else begin
      w_eff = wcfg;
    end
    if (hcfg == '0) begin
      h_eff = CMPW'(1);
    end else if (hcfg > CMPW'(MAX_HEIGHT)) begin
      h_eff = CMPW'(MAX_HEIGHT);
    end else begin
      h_eff = hcfg;
    end
    wm1 = w_eff - CMPW'(1);
    hm1 = h_eff - CMPW'(1);
  end

  // ---------------------------------------------------------------------
  // Accept stage: raster counters, result plan, line store read.
  // ---------------------------------------------------------------------
  logic [XW-1:0] col_r, col_nxt;
  logic [YW-1:0] row_r, row_nxt;
  logic          in_acc, row_end, last_row;
  tag_t          tag_in;
  pix_t          pix_in;

  // Occupancy: queued results plus those promised to items in flight.
  logic [FIFO_CNT_W-1:0] fifo_count;
  logic [FIFO_CNT_W-1:0] pending_r, pending_nxt;
  logic [OCCW-1:0]       occupancy;

  assign occupancy     = OCCW'(fifo_count) + OCCW'(pending_r);
  // Take a pixel only while the queue can absorb its worst-case burst.
  assign in_chan.ready = (occupancy + OCCW'(MAX_RESULTS)) <= OCCW'(FIFO_DEPTH);
  assign in_acc        = in_chan.valid && in_chan.ready;

  always_comb begin
    xw       = CMPW'(col_r);
    yw       = CMPW'(row_r);
    row_end  = (xw >= wm1);
    last_row = (yw >= hm1);

    pix_in.red   = in_chan.in_red;
    pix_in.green = in_chan.in_green;
    pix_in.blue  = in_chan.in_blue;

    tag_in.has_first = (yw >= CMPW'(1)) && (xw >= CMPW'(1));
    tag_in.interior  = (yw >= CMPW'(2)) && (yw <= hm1) && (xw >= CMPW'(2)) && (xw <= wm1);
    tag_in.has_up    = (yw >= CMPW'(1)) && row_end;
    tag_in.has_own   = last_row;
    tag_in.row_end   = row_end;
    tag_in.row       = COORD_W'(row_r);
    tag_in.col       = COORD_W'(col_r);

    // Wrap the column at row end, the row at frame end.
    if (row_end) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_r + 1'b1;
    end else begin
      col_nxt = col_r + 1'b1;
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Line store: entry x holds {older row, recent row} at column x.
  // Read at accept, write back in the next cycle.
  // ---------------------------------------------------------------------
  logic                  s1_valid_r;
  logic [XW-1:0]         s1_addr_r;
  carry_t                s1_carry_r;
  logic                  fwd_hit_r;
  logic [2*PIX_BITS-1:0] fwd_data_r;
  logic [2*PIX_BITS-1:0] mem_rdata, line_rd, line_wdata;
  pix_t                  s1_older, s1_up;
  carry_t                s1_carry;

  bbx_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (XW),
    .DW    (2 * PIX_BITS)
  ) u_line_mem (
    .clk     (clk),
    .we_i    (s1_valid_r),
    .waddr_i (s1_addr_r),
    .wdata_i (line_wdata),
    .re_i    (in_acc),
    .raddr_i (col_r),
    .rdata_o (mem_rdata)
  );

  // A read of the column being written this cycle (width of one) sees
  // stale memory data: take the write data instead.
  always_comb begin
    line_rd        = fwd_hit_r ? fwd_data_r : mem_rdata;
    s1_older       = pix_t'(line_rd[2*PIX_BITS-1:PIX_BITS]);
    s1_up          = pix_t'(line_rd[PIX_BITS-1:0]);
    // Shift the column down: recent row moves to older, new pixel to recent.
    line_wdata     = {s1_up, s1_carry_r.own};
    s1_carry       = s1_carry_r;
    s1_carry.up    = s1_up;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
      fwd_hit_r  <= in_acc && s1_valid_r && (s1_addr_r == col_r);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= line_wdata;
    if (in_acc) begin
      s1_addr_r      <= col_r;
      s1_carry_r.tag <= tag_in;
      s1_carry_r.own <= pix_in;
      s1_carry_r.up  <= pix_in;
    end
  end

  // ---------------------------------------------------------------------
  // Window and arithmetic: three register stages.
  // ---------------------------------------------------------------------
  logic   bl_valid;
  carry_t bl_carry;
  pix_t   bl_blur, bl_center;

  bbx_blur u_blur (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (s1_valid_r),
    .older_i  (s1_older),
    .up_i     (s1_up),
    .carry_i  (s1_carry),
    .valid_o  (bl_valid),
    .carry_o  (bl_carry),
    .blur_o   (bl_blur),
    .center_o (bl_center)
  );

  // ---------------------------------------------------------------------
  // Build the results of one pixel in order: window center, pixel above
  // at row end, own pixel on the last row.
  // ---------------------------------------------------------------------
  logic [MAX_RESULTS-1:0] push;
  res_t                   ent [MAX_RESULTS];
  res_t                   head;
  tag_t                   bt;

  always_comb begin
    bt = bl_carry.tag;

    ent[0].pix  = bt.interior ? bl_blur : bl_center;
    ent[0].row  = bt.row - 1'b1;
    ent[0].col  = bt.col - 1'b1;
    ent[0].last = !bt.has_up && !bt.has_own;
    ent[0].done = 1'b0;

    ent[1].pix  = bl_carry.up;
    ent[1].row  = bt.row - 1'b1;
    ent[1].col  = bt.col;
    ent[1].last = !bt.has_own;
    ent[1].done = 1'b0;

    ent[2].pix  = bl_carry.own;
    ent[2].row  = bt.row;
    ent[2].col  = bt.col;
    ent[2].last = 1'b1;
    ent[2].done = bt.row_end;

    push = {bt.has_own, bt.has_up, bt.has_first} & {MAX_RESULTS{bl_valid}};

    // Reserve at accept, release at push.
    pending_nxt = pending_r
                + (in_acc ? FIFO_CNT_W'(res_count(tag_in)) : '0)
                - (bl_valid ? FIFO_CNT_W'(res_count(bt)) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  bbx_result_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .ent_i   (ent),
    .valid_o (out_chan.valid),
    .ready_i (out_chan.ready),
    .ent_o   (head),
    .count_o (fifo_count)
  );

  assign out_chan.out_red     = head.pix.red;
  assign out_chan.out_green   = head.pix.green;
  assign out_chan.out_blue    = head.pix.blue;
  assign out_chan.out_row     = head.row;
  assign out_chan.out_column  = head.col;
  assign out_chan.last_of_run = head.last;
  assign out_chan.frame_done  = head.done;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `BBX_ASSERT_NXT(a_frame_wrap, in_acc && row_end && last_row,
                  (row_r == '0) && (col_r == '0), "raster counters did not wrap at frame end")
  `BBX_ASSERT_NXT(a_fwd_hit, in_acc && s1_valid_r && (s1_addr_r == col_r),
                  fwd_hit_r, "same-column read missed the write-back forward")
  `BBX_ASSERT_IMP(a_no_overrun, 1'b1, occupancy <= OCCW'(FIFO_DEPTH),
                  "result queue reservation exceeds its depth")
  `BBX_ASSERT_IMP(a_done_is_last, out_chan.valid && out_chan.frame_done,
                  out_chan.last_of_run, "frame end result not marked last of run")

endmodule

>>> tb/sv/rgb_box_blur_3x3_tb.sv
// Self-checking testbench for the 3x3 RGB box blur: frames in, blurred pixels checked out.
module rgb_box_blur_3x3_tb;
  import bbx_pkg::*;

  localparam int MAX_W         = 2048;
  localparam int MAX_H         = 2048;
  localparam int BOX_TAPS      = 9;
  localparam int SETTLE_CYCLES = 16;     // margin for results still in the pipeline
  localparam int HOLD_CYCLES   = 300;    // long output stall for the pressure test
  localparam int RANDOM_PIXELS = 400;
  localparam int CYCLE_LIMIT   = 200000;

  logic clk;
  logic rst_n;

  bbx_cfg_if cfg_bus ();
  bbx_in_if  pix_in ();
  bbx_out_if pix_out ();

  rgb_box_blur_3x3 #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_bus),
    .in_chan  (pix_in),
    .out_chan (pix_out)
  );

  // Shadow of the block: size registers, the two line stores, the 3x3
  // window and the raster position of the next pixel.
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  pix_t             prev2_line [MAX_W];
  pix_t             prev_line [MAX_W];
  pix_t             blur_win [BOX_TAPS];
  int unsigned      row_pos;
  int unsigned      col_pos;

  // Result pixels predicted but not yet seen at the output, oldest first.
  res_t expected_pixels [$];
  int   mismatch_count = 0;

  // Idling controls: the sender's is read only by the stimulus process, the
  // receiver's is written with NBAs so the checker sees it on a clean edge.
  bit   in_idling  = 1'b0;
  bit   out_idling = 1'b0;
  int   hold_req_id = 0;
  int   hold_ack_id = 0;
  int   hold_left   = 0;
  int   rx_gap      = 0;
  logic rx_ready    = 1'b0;

  assign pix_out.ready = rx_ready;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Clamp a size register to the range the block actually uses.
  function automatic int unsigned eff_size(input logic [CFG_W-1:0] v, input int unsigned maxv);
    if (v == '0) return 1;
    if (v > maxv) return maxv;
    return 32'(v);
  endfunction

  function automatic res_t pixel_res(input pix_t v, input int unsigned row,
                                     input int unsigned col, input bit done);
    res_t r;
    r.pix  = v;
    r.row  = COORD_W'(row);
    r.col  = COORD_W'(col);
    r.last = 1'b0;
    r.done = done;
    return r;
  endfunction

  // Advance the shadow by one pixel and queue the results it releases:
  // the window center one row and column back, the right border pixel of
  // the row above at a row end, and the pixel itself on the last row.
  function automatic void predict_blur(input pix_t p);
    int unsigned w, h, x, y, cy, cx;
    int unsigned sum_r, sum_g, sum_b;
    int          i;
    pix_t        above, v;
    bit          row_end, last_row;
    res_t        run [$];
    w     = eff_size(width_reg, MAX_W);
    h     = eff_size(height_reg, MAX_H);
    x     = col_pos % MAX_W;
    y     = row_pos;
    above = prev_line[x];
    for (i = 0; i < 3; i++) begin
      blur_win[i*3]   = blur_win[i*3+1];
      blur_win[i*3+1] = blur_win[i*3+2];
    end
    blur_win[2]   = prev2_line[x];
    blur_win[5]   = above;
    blur_win[8]   = p;
    prev2_line[x] = above;
    prev_line[x]  = p;
    row_end  = (x >= w - 1);
    last_row = (y >= h - 1);

    if (y >= 1 && x >= 1) begin
      cy = y - 1;
      cx = x - 1;
      if (cy >= 1 && cy + 2 <= h && cx >= 1 && cx + 2 <= w) begin
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        for (i = 0; i < BOX_TAPS; i++) begin
          sum_r += blur_win[i].red;
          sum_g += blur_win[i].green;
          sum_b += blur_win[i].blue;
        end
        v.red   = PIX_W'(sum_r / BOX_TAPS);
        v.green = PIX_W'(sum_g / BOX_TAPS);
        v.blue  = PIX_W'(sum_b / BOX_TAPS);
      end else begin
        // Border pixel: pass the window center through.
        v = blur_win[4];
      end
      run.push_back(pixel_res(v, cy, cx, 1'b0));
    end
    if (y >= 1 && row_end) run.push_back(pixel_res(above, y - 1, x, 1'b0));
    if (last_row) run.push_back(pixel_res(p, y, x, row_end));
    if (run.size() > 0) run[run.size()-1].last = 1'b1;
    foreach (run[k]) expected_pixels.push_back(run[k]);

    if (row_end) begin
      col_pos = 0;
      row_pos = last_row ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Check each output transaction against the oldest prediction, then draw
  // the stall before the next one. A pending hold request overrides the drawn stall.
  always @(posedge clk) begin
    res_t want;
    if (rst_n) begin
      if (pix_out.valid && rx_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected output pixel at row %0d column %0d",
                 pix_out.out_row, pix_out.out_column);
          mismatch_count++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("out_red",     16'(want.pix.red),   16'(pix_out.out_red));
          check_field("out_green",   16'(want.pix.green), 16'(pix_out.out_green));
          check_field("out_blue",    16'(want.pix.blue),  16'(pix_out.out_blue));
          check_field("out_row",     16'(want.row),       16'(pix_out.out_row));
          check_field("out_column",  16'(want.col),       16'(pix_out.out_column));
          check_field("last_of_run", 16'(want.last),      16'(pix_out.last_of_run));
          check_field("frame_done",  16'(want.done),      16'(pix_out.frame_done));
        end
        rx_gap = out_idling ? $urandom_range(0, 10) : 0;
      end else if (rx_gap > 0) begin
        rx_gap--;
      end
      if (hold_req_id != hold_ack_id) begin
        hold_ack_id = hold_req_id;
        hold_left   = HOLD_CYCLES;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      rx_ready <= (rx_gap == 0) && (hold_left == 0);
    end
  end

  // Watchdog: end the run if it ever hangs.
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Bias toward the channel extremes so saturated sums show up often.
  function automatic logic [PIX_W-1:0] rand_channel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pix_t rand_pixel();
    pix_t p;
    p.red   = rand_channel();
    p.green = rand_channel();
    p.blue  = rand_channel();
    return p;
  endfunction

  // Offer one pixel and hold it until the input transaction completes.
  task automatic send_pixel(input pix_t p);
    int gap;
    gap = in_idling ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      pix_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_in.valid    <= 1'b1;
    pix_in.in_red   <= p.red;
    pix_in.in_green <= p.green;
    pix_in.in_blue  <= p.blue;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
    predict_blur(p);
  endtask

  task automatic send_frame(input int unsigned count);
    int unsigned i;
    for (i = 0; i < count; i++) send_pixel(rand_pixel());
  endtask

  // Drop valid, wait for every predicted pixel, then let the pipeline settle
  // since pixels that release no result may still be in flight.
  task automatic wait_idle();
    pix_in.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write width then height as one burst on the register port.
  task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    wait_idle();
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= REG_IMAGE_WIDTH;
    cfg_bus.data  <= w;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    width_reg = w;
    cfg_bus.index <= REG_IMAGE_HEIGHT;
    cfg_bus.data  <= h;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    height_reg = h;
    cfg_bus.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Zero sizes clamp to 1x1: each pixel is its own frame and comes straight
  // back with both flags set.
  task automatic test_unit_frames();
    in_idling = 1'b0;
    out_idling <= 1'b0;
    set_frame('0, '0);
    send_pixel('{red: 8'h00, green: 8'h00, blue: 8'h00});
    send_pixel('{red: 8'hFF, green: 8'hFF, blue: 8'hFF});
  endtask

  // Smallest frame with an interior pixel; all ones saturate every sum.
  task automatic test_saturated_interior();
    int i;
    set_frame(12'd3, 12'd3);
    for (i = 0; i < 9; i++) send_pixel('{red: 8'hFF, green: 8'hFF, blue: 8'hFF});
  endtask

  // Start a frame at the largest sizes (height beyond range, clamped), then
  // shrink it while still on the first row: the next pixel closes the row
  // and the second row becomes the last one.
  task automatic test_resize_mid_frame();
    set_frame(12'd2048, 12'd4095);
    send_frame(6);
    set_frame(12'd4, 12'd2);
    send_frame(5);
  endtask

  // Whole frames of random sizes and content, with idling on or off per frame.
  task automatic test_random_frames();
    int unsigned      sent;
    logic [CFG_W-1:0] w, h;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      case ($urandom_range(0, 9))
        0:       w = '0;
        1:       w = CFG_W'($urandom_range(24, 48));
        default: w = CFG_W'($urandom_range(1, 10));
      endcase
      h = ($urandom_range(0, 9) == 0) ? '0 : CFG_W'($urandom_range(1, 6));
      in_idling = ($urandom_range(0, 3) != 0);
      out_idling <= ($urandom_range(0, 3) != 0);
      set_frame(w, h);
      send_frame(eff_size(w, MAX_W) * eff_size(h, MAX_H));
      sent += eff_size(w, MAX_W) * eff_size(h, MAX_H);
    end
  endtask

  // Stall the output for a long stretch while pixels keep coming, so the
  // result queue fills and the input must back off.
  task automatic test_output_backpressure();
    in_idling = 1'b0;
    out_idling <= 1'b0;
    set_frame(12'd8, 12'd4);
    hold_req_id <= hold_req_id + 1;
    send_frame(32);
  endtask

  initial begin
    int i;
    rst_n           = 1'b0;
    pix_in.valid    = 1'b0;
    pix_in.in_red   = '0;
    pix_in.in_green = '0;
    pix_in.in_blue  = '0;
    cfg_bus.valid   = 1'b0;
    cfg_bus.index   = REG_IMAGE_WIDTH;
    cfg_bus.data    = '0;
    width_reg       = CFG_RESET_SIZE;
    height_reg      = CFG_RESET_SIZE;
    row_pos         = 0;
    col_pos         = 0;
    for (i = 0; i < MAX_W; i++) begin
      prev2_line[i] = '0;
      prev_line[i]  = '0;
    end
    for (i = 0; i < BOX_TAPS; i++) blur_win[i] = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_unit_frames();
    test_saturated_interior();
    test_resize_mid_frame();
    test_random_frames();
    test_output_backpressure();

    wait_idle();
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
